// ----- design/particle_pool_update_core_macros.svh -----
// Assertion macros shared by the particle pool RTL.
`ifndef PARTICLE_POOL_UPDATE_CORE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ppu_pkg.sv -----
// Types and constants of the particle pool update core.
`timescale 1ns / 1ps

package ppu_pkg;

	localparam int POOL_SIZE_DEF = 32;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_CREATE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] RK_CREATE = 2'd0;
	localparam logic [1:0] RK_PART   = 2'd1;
	localparam logic [1:0] RK_EMPTY  = 2'd2;
	localparam logic [1:0] RK_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [1:0]         kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic [15:0]        life_ticks;
	} req_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic               accepted;
		logic [1:0]         out_kind;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_vx;
		logic signed [15:0] out_vy;
		logic [15:0]        out_life;
		logic [15:0]        out_max_life;
		logic               last;
	} res_t;

	// One stored particle, as kept in the pool memory.
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic [15:0]        life;
		logic [15:0]        max_life;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- design/ppu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ppu_sat_add.sv -----
// Shared 16-bit signed saturating adder for position updates.
`timescale 1ns / 1ps

module ppu_sat_add (
	input  logic signed [15:0] a,
	input  logic signed [15:0] b,
	output logic signed [15:0] y
);

	logic [16:0] sum;

	assign sum = {a[15], a} + {b[15], b};

	always_comb begin
		if (sum[16] != sum[15]) begin
			y = sum[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			y = sum[15:0];
		end
	end

endmodule

// ----- design/particle_pool_update_core.sv -----
// Top level: particle pool with create, clear and tick-update sequencer.
`timescale 1ns / 1ps
`include "particle_pool_update_core_macros.svh"

//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------
//  request   | req_valid / req_stall     | req (ppu_pkg::req_t)
//  result    | res_valid / res_stall     | res (ppu_pkg::res_t)
//
// A tick reads each stored particle in turn; the single pool RAM read port and
// the one saturating adder (x, then y) set the tick pace.
// Reset clears the sequencer and the live count; the pool RAM is not cleared.
// res_stall holds the output register; a tick scan waits only when a new survivor
// must push the previous one out while that register is held. req_stall is high while busy.

module particle_pool_update_core #(
	parameter int POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ppu_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output ppu_pkg::res_t res
);

	localparam int CNT_W = $clog2(POOL_SIZE + 1);
	localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CRT  = 6'b000010,
		ST_RD   = 6'b000100,
		ST_EVX  = 6'b001000,
		ST_EVY  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] w_q;
	logic             pend_v_q;
	logic             out_valid_q;

	ppu_pkg::req_t    req_q;
	ppu_pkg::res_t    pend_q;
	ppu_pkg::res_t    fin_q;
	ppu_pkg::res_t    out_q;
	logic signed [15:0] x_new_q;

	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [ppu_pkg::ENTRY_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [ppu_pkg::ENTRY_W-1:0] ram_rdata;

	ppu_pkg::entry_t rd_entry;
	ppu_pkg::entry_t upd_entry;
	ppu_pkg::entry_t new_entry;
	ppu_pkg::res_t   upd_res;
	ppu_pkg::res_t   out_d;
	ppu_pkg::res_t   fin_d;
	logic            fin_ld;

	logic signed [15:0] alu_a;
	logic signed [15:0] alu_b;
	logic signed [15:0] alu_y;

	logic req_acc;
	logic out_free;
	logic scan_end;
	logic survive;
	logic need_push;
	logic evy_go;
	logic load_out;
	logic pool_ok;

	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !res_stall;
	assign scan_end  = (i_q == cnt_q);
	assign pool_ok   = (cnt_q < CNT_W'(POOL_SIZE));

	assign rd_entry = ppu_pkg::entry_t'(ram_rdata);
	assign survive  = (rd_entry.life > 16'd1);

	// One adder serves x in ST_EVX and y in ST_EVY.
	assign alu_a = (state_q == ST_EVX) ? rd_entry.x  : rd_entry.y;
	assign alu_b = (state_q == ST_EVX) ? rd_entry.vx : rd_entry.vy;

	ppu_sat_add u_add (
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	always_comb begin
		upd_entry          = rd_entry;
		upd_entry.x        = x_new_q;
		upd_entry.y        = alu_y;
		upd_entry.life     = rd_entry.life - 16'd1;

		new_entry          = '0;
		new_entry.kind     = req_q.kind;
		new_entry.x        = req_q.pos_x;
		new_entry.y        = req_q.pos_y;
		new_entry.vx       = req_q.vel_x;
		new_entry.vy       = req_q.vel_y;
		new_entry.life     = req_q.life_ticks;
		new_entry.max_life = req_q.life_ticks;

		upd_res              = '0;
		upd_res.result_kind  = ppu_pkg::RK_PART;
		upd_res.out_kind     = upd_entry.kind;
		upd_res.out_x        = upd_entry.x;
		upd_res.out_y        = upd_entry.y;
		upd_res.out_vx       = upd_entry.vx;
		upd_res.out_vy       = upd_entry.vy;
		upd_res.out_life     = upd_entry.life;
		upd_res.out_max_life = upd_entry.max_life;
	end

	// Final result of a request: clear, create answer, last survivor or empty marker.
	always_comb begin
		fin_ld     = 1'b0;
		fin_d      = '0;
		fin_d.last = 1'b1;
		if (req_acc && (req.opcode == ppu_pkg::OP_CLEAR)) begin
			fin_ld            = 1'b1;
			fin_d.result_kind = ppu_pkg::RK_CLEAR;
		end else if (state_q == ST_CRT) begin
			fin_ld            = 1'b1;
			fin_d.result_kind = ppu_pkg::RK_CREATE;
			fin_d.accepted    = pool_ok;
		end else if ((state_q == ST_RD) && scan_end) begin
			fin_ld = 1'b1;
			if (pend_v_q) begin
				fin_d      = pend_q;
				fin_d.last = 1'b1;
			end else begin
				fin_d.result_kind = ppu_pkg::RK_EMPTY;
			end
		end
	end

	// A survivor is sent early only once the next one proves it is not last; else at scan end.
	assign need_push = survive && pend_v_q;
	assign evy_go    = (state_q == ST_EVY) && (!need_push || out_free);
	assign load_out  = ((state_q == ST_FIN) && out_free) ||
	                   ((state_q == ST_EVY) && need_push && out_free);
	assign out_d     = (state_q == ST_FIN) ? fin_q : pend_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_q[IDX_W-1:0];
		ram_wdata = upd_entry;
		if ((state_q == ST_CRT) && pool_ok) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[IDX_W-1:0];
			ram_wdata = new_entry;
		end else if (evy_go && survive) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = (state_q == ST_RD) && !scan_end;

	ppu_ram #(
		.WIDTH (ppu_pkg::ENTRY_W),
		.DEPTH (POOL_SIZE)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (i_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			i_q         <= '0;
			w_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						unique case (req.opcode)
							ppu_pkg::OP_TICK: begin
								i_q      <= '0;
								w_q      <= '0;
								pend_v_q <= 1'b0;
								state_q  <= ST_RD;
							end
							ppu_pkg::OP_CREATE: begin
								state_q <= ST_CRT;
							end
							ppu_pkg::OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CRT: begin
					if (pool_ok) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_RD: begin
					if (scan_end) begin
						cnt_q   <= w_q;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_EVX;
					end
				end
				ST_EVX: begin
					state_q <= ST_EVY;
				end
				ST_EVY: begin
					if (evy_go) begin
						if (survive) begin
							w_q      <= w_q + 1'b1;
							pend_v_q <= 1'b1;
						end
						i_q     <= i_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
		end
		if (fin_ld) begin
			fin_q <= fin_d;
		end
		if (state_q == ST_EVX) begin
			x_new_q <= alu_y;
		end
		if (evy_go && survive) begin
			pend_q <= upd_res;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`PPU_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(POOL_SIZE), "live count above pool size")
	`PPU_ASSERT_IMP(a_compact_order, clk, arst_n, state_q == ST_EVY, w_q <= i_q, "compaction write index passed read index")
	`PPU_ASSERT_IMP(a_out_load_free, clk, arst_n, load_out, out_free, "output register overwritten while held")
	`PPU_ASSERT_NXT(a_tick_count, clk, arst_n, (state_q == ST_RD) && scan_end, cnt_q == $past(w_q), "live count not set to survivor count")

endmodule

// ----- dv/particle_pool_update_core_tb.sv -----
// Self-checking testbench of the particle pool update core.
`timescale 1ns / 1ps

module particle_pool_update_core_tb;

	localparam int POOL        = ppu_pkg::POOL_SIZE_DEF;
	localparam int RANDOM_REQS = 95;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 200;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] OP_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ppu_pkg::req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ppu_pkg::res_t res;

	ppu_pkg::req_t   req_backlog[$];
	ppu_pkg::res_t   due_results[$];
	ppu_pkg::entry_t pool_mirror[POOL];
	int              mirror_count = 0;

	int errors = 0;
	int cycle_count = 0;
	int req_count = 0;
	bit calm = 1'b0;
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	particle_pool_update_core #(.POOL_SIZE(POOL)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [15:0] sat_add(logic signed [15:0] a, logic signed [15:0] b);
		int s;
		s = int'(a) + int'(b);
		if (s > 32767)
			return 16'sh7FFF;
		if (s < -32768)
			return 16'sh8000;
		return s[15:0];
	endfunction

	// Applies one accepted request to the mirror and queues the results it causes.
	task automatic advance_pool(input ppu_pkg::req_t r);
		ppu_pkg::res_t   o;
		ppu_pkg::entry_t e;
		int              w;
		o = '0;
		o.last = 1'b1;
		case (r.opcode)
			ppu_pkg::OP_CREATE: begin
				o.result_kind = ppu_pkg::RK_CREATE;
				if (mirror_count < POOL) begin
					e.kind = r.kind;
					e.x = r.pos_x;
					e.y = r.pos_y;
					e.vx = r.vel_x;
					e.vy = r.vel_y;
					e.life = r.life_ticks;
					e.max_life = r.life_ticks;
					pool_mirror[mirror_count] = e;
					mirror_count++;
					o.accepted = 1'b1;
				end
				due_results.push_back(o);
			end
			ppu_pkg::OP_CLEAR: begin
				mirror_count = 0;
				o.result_kind = ppu_pkg::RK_CLEAR;
				due_results.push_back(o);
			end
			ppu_pkg::OP_TICK: begin
				w = 0;
				for (int i = 0; i < mirror_count; i++) begin
					e = pool_mirror[i];
					// zero or one tick left: dropped on this tick
					if (e.life <= 16'd1)
						continue;
					e.x = sat_add(e.x, e.vx);
					e.y = sat_add(e.y, e.vy);
					e.life = e.life - 16'd1;
					pool_mirror[w] = e;
					w++;
				end
				mirror_count = w;
				if (w == 0) begin
					o.result_kind = ppu_pkg::RK_EMPTY;
					due_results.push_back(o);
				end
				for (int i = 0; i < w; i++) begin
					o = '0;
					o.result_kind = ppu_pkg::RK_PART;
					o.out_kind = pool_mirror[i].kind;
					o.out_x = pool_mirror[i].x;
					o.out_y = pool_mirror[i].y;
					o.out_vx = pool_mirror[i].vx;
					o.out_vy = pool_mirror[i].vy;
					o.out_life = pool_mirror[i].life;
					o.out_max_life = pool_mirror[i].max_life;
					o.last = (i == w - 1);
					due_results.push_back(o);
				end
			end
			default: ;
		endcase
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Request driver: payload only moves when the slot is empty or just accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				advance_pool(req);
			if (!req_valid || !req_stall) begin
				if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver-side stall.
	always @(posedge clk) begin
		ppu_pkg::res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					$error("result with nothing expected: result_kind %0d", res.result_kind);
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("result_kind", 16'(want.result_kind), 16'(res.result_kind));
					check_field("accepted", 16'(want.accepted), 16'(res.accepted));
					check_field("out_kind", 16'(want.out_kind), 16'(res.out_kind));
					check_field("out_x", want.out_x, res.out_x);
					check_field("out_y", want.out_y, res.out_y);
					check_field("out_vx", want.out_vx, res.out_vx);
					check_field("out_vy", want.out_vy, res.out_vy);
					check_field("out_life", want.out_life, res.out_life);
					check_field("out_max_life", want.out_max_life, res.out_max_life);
					check_field("last", 16'(want.last), 16'(res.last));
				end
			end
			if (hold_arm && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				res_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !calm && ($urandom_range(0, 99) < 33);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Keeps the backlog short so that the stimulus phases track simulation time.
	task automatic queue_request(input ppu_pkg::req_t r);
		while (req_backlog.size() >= 4)
			@(negedge clk);
		req_backlog.push_back(r);
		if (r.opcode != OP_NONE)
			req_count++;
	endtask

	task automatic wait_drained();
		while (req_backlog.size() != 0 || req_valid || due_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic ppu_pkg::req_t make_req(logic [1:0] op, logic [1:0] kind,
			logic [15:0] x, logic [15:0] y, logic [15:0] vx, logic [15:0] vy,
			logic [15:0] life);
		ppu_pkg::req_t r;
		r.opcode = op;
		r.kind = kind;
		r.pos_x = x;
		r.pos_y = y;
		r.vel_x = vx;
		r.vel_y = vy;
		r.life_ticks = life;
		return r;
	endfunction

	function automatic logic [15:0] rand_q88();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic ppu_pkg::req_t rand_create();
		logic [15:0] life;
		case ($urandom_range(0, 9))
			0: life = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1, 2: life = 16'($urandom);
			default: life = 16'($urandom_range(0, 8));
		endcase
		return make_req(ppu_pkg::OP_CREATE, 2'($urandom_range(0, 3)), rand_q88(),
			rand_q88(), rand_q88(), rand_q88(), life);
	endfunction

	function automatic ppu_pkg::req_t rand_req(logic [1:0] op);
		return make_req(op, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	initial begin
		int sel;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty tick, extremes, lifetimes 0/1/2, saturation, ignored opcode
		queue_request(make_req(ppu_pkg::OP_TICK, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		queue_request(make_req(ppu_pkg::OP_CREATE, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0));
		queue_request(make_req(ppu_pkg::OP_CREATE, 2'd1, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'h1));
		queue_request(make_req(ppu_pkg::OP_CREATE, 2'd2, 16'h7FFF, 16'h8000, 16'h0001,
			16'hFFFF, 16'h2));
		queue_request(make_req(ppu_pkg::OP_CREATE, 2'd3, 16'h8000, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'hFFFF));
		queue_request(make_req(ppu_pkg::OP_CREATE, 2'd1, 16'h1234, 16'hEDCB, 16'hFEDC,
			16'h0123, 16'h3));
		queue_request(rand_req(OP_NONE));
		queue_request(make_req(ppu_pkg::OP_TICK, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		queue_request(make_req(ppu_pkg::OP_TICK, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		queue_request(rand_req(ppu_pkg::OP_CLEAR));
		queue_request(make_req(ppu_pkg::OP_TICK, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		queue_request(make_req(ppu_pkg::OP_CREATE, 2'd0, 16'h00FF, 16'hFF00, 16'h0100,
			16'hFF00, 16'h2));
		queue_request(rand_req(ppu_pkg::OP_TICK));
		queue_request(rand_req(ppu_pkg::OP_TICK));
		queue_request(rand_req(OP_NONE));
		queue_request(rand_req(ppu_pkg::OP_CLEAR));
		wait_drained();

		// fill the pool past full, then hold results while ticks pile up
		req_count = 0;
		repeat (POOL + 2)
			queue_request(make_req(ppu_pkg::OP_CREATE, 2'($urandom_range(0, 3)), rand_q88(),
				rand_q88(), rand_q88(), rand_q88(), 16'($urandom_range(2, 65535))));
		hold_arm = 1'b1;
		repeat (4)
			queue_request(rand_req(ppu_pkg::OP_TICK));
		queue_request(rand_req(ppu_pkg::OP_CLEAR));

		while (req_count < RANDOM_REQS) begin
			calm = (req_count >= 50 && req_count < 80);
			sel = $urandom_range(0, 99);
			if (sel < 65) begin
				n = $urandom_range(1, 8);
				repeat (n)
					queue_request(rand_create());
				n = $urandom_range(1, 4);
				repeat (n)
					queue_request(rand_req(ppu_pkg::OP_TICK));
			end else if (sel < 73) begin
				queue_request(rand_req(ppu_pkg::OP_CLEAR));
			end else if (sel < 85) begin
				queue_request(rand_req(2'($urandom_range(0, 3))));
			end else if (sel < 92) begin
				wait_drained();
			end else begin
				queue_request(rand_req(OP_NONE));
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
